// ===== hw/rtl/ubfc_pkg.sv =====
// Shared types and constants for the unit box frustum cull block.
// Used by every module under hw/rtl; depends on nothing else.
package ubfc_pkg;

    localparam int ELEM_W     = 32;    // Q16.16 matrix element
    localparam int PLANE_W    = 33;    // row3 +/- row k, exact
    localparam int PAIR_W     = 34;    // sum of two plane terms
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int NUM_STORED = 3;     // columns 0..2 are kept
    localparam int NUM_PLANES = 6;
    localparam int IN_DATA_W  = 136;   // 2 + 4*32 = 130, padded to bytes
    localparam int OUT_DATA_W = 8;

    localparam logic [1:0] COL_TRIGGER = 2'd3;

    typedef logic signed [ELEM_W-1:0]  t_elem;
    typedef logic signed [PLANE_W-1:0] t_pterm;
    typedef logic signed [PAIR_W-1:0]  t_pair;

    // [matrix column][matrix row]
    typedef t_elem [NUM_COLS-1:0][NUM_ROWS-1:0] t_mat;

    // One clip plane: w plus the positive parts of x, y and z. The largest
    // corner sum of a plane is w + max(0,x) + max(0,y) + max(0,z).
    typedef struct packed {
        t_pterm w;
        t_pterm px;
        t_pterm py;
        t_pterm pz;
    } t_plane;

    typedef t_plane [NUM_PLANES-1:0] t_planes;

    // Largest corner sum split into two registered halves.
    typedef struct packed {
        t_pair a;   // w + max(0,x)
        t_pair b;   // max(0,y) + max(0,z)
    } t_half;

    typedef t_half [NUM_PLANES-1:0] t_halves;

endpackage

// ===== hw/rtl/unit_box_frustum_cull.sv =====
// Top level of the unit box frustum cull block: column store, input
// register and the plane and corner stages. Depends on ubfc_pkg,
// ubfc_plane and ubfc_corner.
//
// Takes a 4x4 matrix one column per item and gives one visible/culled
// result for each column 3 item, testing the unit cube [0,1]^3 against the
// six clip planes (row 3 plus or minus rows 0, 1, 2). Columns 0..2 are
// written into the store at the edge they are accepted and produce no
// result; all three must be written before the first column 3. One item is
// taken every cycle unless the input register holds a column 3 item that
// the plane stage cannot yet take. A column 3 item goes through the input
// register (loaded at the accepting edge), then the plane, corner half-sum
// and result registers, and every stage holds under output back-pressure.
module unit_box_frustum_cull (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] column, [33:2] row_zero, [65:34] row_one, [97:66] row_two,
    // [129:98] row_three, [135:130] zero
    input  logic [ubfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] visible, [7:1] zero
    output logic [ubfc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ubfc_pkg::*;

    t_elem     r_store [NUM_STORED][NUM_ROWS];
    t_elem     r_last  [NUM_ROWS];
    logic      r_vld;
    logic [1:0] in_col;
    t_elem     in_row  [NUM_ROWS];
    logic      accept;
    logic      plane_rdy;
    t_mat      mat;
    t_planes   planes;
    logic      planes_vld;
    logic      corner_rdy;
    logic      visible;

    assign in_col = s_axis_tdata[1:0];
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            in_row[r] = s_axis_tdata[2 + r*ELEM_W +: ELEM_W];
        end
    end

    assign s_axis_tready = !r_vld || plane_rdy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // The store is read by the plane stage before any later write lands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_vld <= s_axis_tvalid && (in_col == COL_TRIGGER);
        end
        for (int c = 0; c < NUM_STORED; c++) begin
            if (accept && (in_col == 2'(c))) begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    r_store[c][r] <= in_row[r];
                end
            end
        end
        if (accept && (in_col == COL_TRIGGER)) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_last[r] <= in_row[r];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_STORED; c++) begin
                mat[c][r] = r_store[c][r];
            end
            mat[NUM_COLS-1][r] = r_last[r];
        end
    end

    ubfc_plane u_plane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld),
        .o_rdy    (plane_rdy),
        .i_mat    (mat),
        .o_vld    (planes_vld),
        .i_rdy    (corner_rdy),
        .o_planes (planes)
    );

    ubfc_corner u_corner (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (planes_vld),
        .o_rdy     (corner_rdy),
        .i_planes  (planes),
        .o_vld     (m_axis_tvalid),
        .i_rdy     (m_axis_tready),
        .o_visible (visible)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, visible};

endmodule

// ===== hw/rtl/ubfc_plane.sv =====
// Plane stage: forms the six clip planes from the full matrix and keeps
// the positive parts of x, y, z. Depends on ubfc_pkg.
module ubfc_plane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  ubfc_pkg::t_mat    i_mat,
    output logic              o_vld,
    input  logic              i_rdy,
    output ubfc_pkg::t_planes o_planes
);
    import ubfc_pkg::*;

    logic    r_vld;
    t_planes r_planes;
    t_planes n_planes;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        t_pterm comp_p [NUM_COLS];
        t_pterm comp_m [NUM_COLS];
        n_planes = '0;
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                comp_p[c] = {i_mat[c][3][ELEM_W-1], i_mat[c][3]}
                          + {i_mat[c][k][ELEM_W-1], i_mat[c][k]};
                comp_m[c] = {i_mat[c][3][ELEM_W-1], i_mat[c][3]}
                          - {i_mat[c][k][ELEM_W-1], i_mat[c][k]};
            end
            n_planes[2*k].w    = comp_p[3];
            n_planes[2*k].px   = comp_p[0][PLANE_W-1] ? '0 : comp_p[0];
            n_planes[2*k].py   = comp_p[1][PLANE_W-1] ? '0 : comp_p[1];
            n_planes[2*k].pz   = comp_p[2][PLANE_W-1] ? '0 : comp_p[2];
            n_planes[2*k+1].w  = comp_m[3];
            n_planes[2*k+1].px = comp_m[0][PLANE_W-1] ? '0 : comp_m[0];
            n_planes[2*k+1].py = comp_m[1][PLANE_W-1] ? '0 : comp_m[1];
            n_planes[2*k+1].pz = comp_m[2][PLANE_W-1] ? '0 : comp_m[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_planes <= n_planes;
        end
    end

    assign o_vld    = r_vld;
    assign o_planes = r_planes;

endmodule

// ===== hw/rtl/ubfc_corner.sv =====
// Corner stage: largest corner sum of each plane in two registered adds,
// then the cull decision into the result register. Depends on ubfc_pkg.
module ubfc_corner (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  ubfc_pkg::t_planes i_planes,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic              o_visible
);
    import ubfc_pkg::*;

    logic    r_hvld;
    t_halves r_halves;
    t_halves n_halves;
    logic    r_vld;
    logic    r_visible;
    logic    n_visible;
    logic    hrdy;

    assign hrdy  = !r_vld || i_rdy;
    assign o_rdy = !r_hvld || hrdy;

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            n_halves[p].a = {i_planes[p].w[PLANE_W-1], i_planes[p].w}
                          + {i_planes[p].px[PLANE_W-1], i_planes[p].px};
            n_halves[p].b = {i_planes[p].py[PLANE_W-1], i_planes[p].py}
                          + {i_planes[p].pz[PLANE_W-1], i_planes[p].pz};
        end
    end

    // A plane culls when even its largest corner sum is negative.
    always_comb begin
        logic signed [PAIR_W:0] top;
        n_visible = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            top = {r_halves[p].a[PAIR_W-1], r_halves[p].a}
                + {r_halves[p].b[PAIR_W-1], r_halves[p].b};
            if (top[PAIR_W]) begin
                n_visible = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            if (o_rdy) begin
                r_hvld <= i_vld;
            end
            if (hrdy) begin
                r_vld <= r_hvld;
            end
        end
        if (o_rdy && i_vld) begin
            r_halves <= n_halves;
        end
        if (hrdy && r_hvld) begin
            r_visible <= n_visible;
        end
    end

    assign o_vld     = r_vld;
    assign o_visible = r_visible;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for unit_box_frustum_cull: streams matrix columns in and
// checks every visible/culled item against a built-in plane/corner predictor.
// Depends on ubfc_pkg and the unit_box_frustum_cull RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ubfc_pkg::*;

    localparam logic [1:0] COL_X = 2'd0;
    localparam logic [1:0] COL_Y = 2'd1;
    localparam logic [1:0] COL_Z = 2'd2;

    localparam t_elem Q_ONE    = 32'sh0001_0000;
    localparam t_elem ELEM_MIN = 32'sh8000_0000;
    localparam t_elem ELEM_MAX = 32'sh7fff_ffff;

    localparam int NUM_ITEMS = 700;

    typedef enum int unsigned {ANY_BITS, NEAR_UNITY, EDGE_VALUES, FEW_LSBS} t_val_mix;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [1:0] column, [33:2] row_zero, [65:34] row_one, [97:66] row_two,
    // [129:98] row_three, [135:130] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] visible, [7:1] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [IN_DATA_W-1:0] pending_cols [$];
    logic                 visible_due [$];
    t_elem                mat_store [NUM_STORED][NUM_ROWS];

    int unsigned items_taken = 0;
    int unsigned fail_count = 0;
    int unsigned src_idle_pct = 30;
    int unsigned snk_idle_pct = 30;
    int unsigned src_wait = 0;
    int unsigned snk_wait = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    logic        hold_off = 1'b0;

    unit_box_frustum_cull dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Six planes row3 +/- row k; culled if any plane has all eight corners < 0.
    // Sums are kept at 35 bits so nothing wraps.
    function automatic logic predict_visible(input t_elem trig [NUM_ROWS]);
        logic signed [34:0] pl [NUM_ROWS];
        logic signed [34:0] e3;
        logic signed [34:0] ek;
        logic signed [34:0] corner;
        int                 neg;
        logic               vis;
        vis = 1'b1;
        for (int k = 0; k < 3; k++) begin
            for (int sgn = 0; sgn < 2; sgn++) begin
                for (int c = 0; c < NUM_COLS; c++) begin
                    e3 = 35'((c < NUM_STORED) ? mat_store[c][3] : trig[3]);
                    ek = 35'((c < NUM_STORED) ? mat_store[c][k] : trig[k]);
                    pl[c] = sgn ? (e3 - ek) : (e3 + ek);
                end
                neg = 0;
                for (int n = 0; n < 8; n++) begin
                    corner = pl[3];
                    if (n[0]) corner += pl[0];
                    if (n[1]) corner += pl[1];
                    if (n[2]) corner += pl[2];
                    if (corner < 0) neg++;
                end
                if (neg == 8) vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic int unsigned draw_idle(input int unsigned pct);
        return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic t_elem rand_elem(input t_val_mix mix);
        case (mix)
            ANY_BITS:   return t_elem'($urandom);
            NEAR_UNITY: return t_elem'(int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
            EDGE_VALUES: begin
                case ($urandom_range(0, 6))
                    0:       return ELEM_MIN;
                    1:       return ELEM_MAX;
                    2:       return '0;
                    3:       return -32'sd1;
                    4:       return 32'sd1;
                    5:       return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default:    return t_elem'(int'($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic push_col(input logic [1:0] col, input t_elem r0, input t_elem r1,
                            input t_elem r2, input t_elem r3);
        pending_cols.push_back({{(IN_DATA_W - 130){1'b0}}, r3, r2, r1, r0, col});
    endtask

    // A full matrix: columns in order, then the trigger column.
    task automatic push_matrix(input t_val_mix mix);
        logic     per_elem;
        t_val_mix m [4];
        per_elem = ($urandom_range(0, 3) == 0);
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++)
                m[r] = per_elem ? t_val_mix'($urandom_range(0, 3)) : mix;
            push_col(2'(c), rand_elem(m[0]), rand_elem(m[1]), rand_elem(m[2]),
                     rand_elem(m[3]));
        end
    endtask

    // Input side: store columns 0..2 and predict on every accepted column 3 item.
    always @(posedge i_clk) begin : in_side
        logic [1:0] col;
        t_elem      rowv [NUM_ROWS];
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            col = s_axis_tdata[1:0];
            for (int r = 0; r < NUM_ROWS; r++)
                rowv[r] = s_axis_tdata[2 + ELEM_W * r +: ELEM_W];
            if (col == COL_TRIGGER)
                visible_due.push_back(predict_visible(rowv));
            else
                mat_store[col] = rowv;
            items_taken <= items_taken + 1;
            if (items_taken % 100 == 99) begin
                src_idle_pct <= 20 * $urandom_range(0, 5);
                snk_idle_pct <= 20 * $urandom_range(0, 5);
            end
        end
    end

    always @(negedge i_clk) begin : driver
        if (in_taken) src_wait = draw_idle(src_idle_pct);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // still waiting for the handshake
        end else if (src_wait > 0) begin
            src_wait--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_cols.size() > 0) begin
            s_axis_tdata  <= pending_cols.pop_front();
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        out_taken <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (visible_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result visible=%0b", m_axis_tdata[0]));
            end else if (m_axis_tdata[0] !== visible_due[0]) begin
                report_mismatch($sformatf("visible got %0b want %0b", m_axis_tdata[0],
                                          visible_due[0]));
                void'(visible_due.pop_front());
            end else begin
                void'(visible_due.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin : sink_ready
        if (out_taken) snk_wait = draw_idle(snk_idle_pct);
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (snk_wait > 0) begin
            snk_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Long output stall while the sender keeps going, so the pipe backs up.
    initial begin
        wait (items_taken >= 150);
        @(posedge i_clk) hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("unit_box_frustum_cull test failed");
        $finish;
    end

    initial begin
        // identity: box inside
        push_col(COL_X, Q_ONE, '0, '0, '0);
        push_col(COL_Y, '0, Q_ONE, '0, '0);
        push_col(COL_Z, '0, '0, Q_ONE, '0);
        push_col(COL_TRIGGER, '0, '0, '0, Q_ONE);
        // shifted far along x: right plane culls; trigger only, store reused
        push_col(COL_TRIGGER, 32'sh0005_0000, '0, '0, Q_ONE);
        // all-zero matrix: zero planes never cull
        push_col(COL_X, '0, '0, '0, '0);
        push_col(COL_Y, '0, '0, '0, '0);
        push_col(COL_Z, '0, '0, '0, '0);
        push_col(COL_TRIGGER, '0, '0, '0, '0);
        // w one LSB below zero: every corner strictly negative
        push_col(COL_TRIGGER, '0, '0, '0, -32'sd1);
        // full-scale extremes, sums must not wrap
        push_col(COL_X, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
        push_col(COL_Y, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
        push_col(COL_Z, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
        push_col(COL_TRIGGER, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
        push_col(COL_X, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
        push_col(COL_Y, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
        push_col(COL_Z, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
        push_col(COL_TRIGGER, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
        push_col(COL_TRIGGER, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MIN);

        // mostly complete matrices, some lone column rewrites as noise
        while (pending_cols.size() < NUM_ITEMS) begin
            if ($urandom_range(0, 3) != 0)
                push_matrix(t_val_mix'($urandom_range(0, 3)));
            else
                push_col(2'($urandom_range(0, 3)), rand_elem(t_val_mix'($urandom_range(0, 3))),
                         rand_elem(t_val_mix'($urandom_range(0, 3))),
                         rand_elem(t_val_mix'($urandom_range(0, 3))),
                         rand_elem(t_val_mix'($urandom_range(0, 3))));
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cols.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (visible_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("unit_box_frustum_cull test passed");
        else
            $display("unit_box_frustum_cull test failed");
        $finish;
    end

endmodule
